FILE: rtl/bdenc_pkg.sv
// Shared constants and types for the block delta encoder.
// No dependencies; every other file imports this package.
`default_nettype none
package bdenc_pkg;

    localparam int BYTE_W = 8;
    localparam int BLOCK_BYTES_DEF = 32;
    localparam int CNT_W = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] FLAG_MATCH   = 8'd0;
    localparam logic [BYTE_W-1:0] FLAG_LITERAL = 8'd1;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             differs;
    } blk_desc_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [CNT_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } buf_wr_t;

endpackage
`default_nettype wire

FILE: rtl/bdenc_in_if.sv
// Input channel: a snapshot byte with its reference byte and flags.
// Depends on bdenc_pkg for the byte width.
`default_nettype none
interface bdenc_in_if;
    import bdenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] snap_byte;
    logic [BYTE_W-1:0] ref_byte;
    logic              ref_present;
    logic              final_byte;

    modport source (output valid, snap_byte, ref_byte, ref_present, final_byte,
                    input ready);
    modport sink (input valid, snap_byte, ref_byte, ref_present, final_byte,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/bdenc_out_if.sv
// Output channel: one encoded byte with its flag and end-of-run marks.
// Depends on bdenc_pkg for the byte width.
`default_nettype none
interface bdenc_out_if;
    import bdenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_flag;
    logic              run_end;

    modport source (output valid, out_byte, is_flag, run_end, input ready);
    modport sink (input valid, out_byte, is_flag, run_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdenc_front.sv
// Front end: accepts input bytes, writes them into the block buffer and
// closes blocks into descriptors. Depends on bdenc_pkg and bdenc_in_if.
`default_nettype none
module bdenc_front #(
    parameter int BLOCK_BYTES = bdenc_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    bdenc_in_if.sink                 feed,
    input  wire logic                q_full,
    output logic                     push,
    output bdenc_pkg::blk_desc_t     push_desc,
    output bdenc_pkg::buf_wr_t       wr
);
    import bdenc_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             differs_reg, differs_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic [CNT_W-1:0] fill_inc;
    logic             diff_acc;
    logic             close;

    assign feed.ready = !q_full;
    assign accept     = feed.valid && !q_full;
    assign fill_inc   = fill_reg + CNT_W'(1);
    assign diff_acc   = differs_reg || !feed.ref_present
                        || (feed.snap_byte != feed.ref_byte);
    assign close      = (fill_inc == CNT_W'(BLOCK_BYTES)) || feed.final_byte;

    always_comb
    begin
        fill_next    = fill_reg;
        differs_next = differs_reg;
        bank_next    = bank_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (close)
            begin
                push         = 1'b1;
                fill_next    = '0;
                differs_next = 1'b0;
                bank_next    = !bank_reg;
            end
            else
            begin
                fill_next    = fill_inc;
                differs_next = diff_acc;
            end
        end
    end

    always_comb
    begin
        push_desc.bank    = bank_reg;
        push_desc.count   = fill_inc;
        push_desc.differs = diff_acc;
        wr.en             = accept;
        wr.bank           = bank_reg;
        wr.idx            = fill_reg;
        wr.data           = feed.snap_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            differs_reg <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            differs_reg <= differs_next;
            bank_reg    <= bank_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bdenc_queue.sv
// Two-entry descriptor queue between the front end and the back end.
// Depends on bdenc_pkg.
`default_nettype none
module bdenc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bdenc_pkg::blk_desc_t push_desc,
    input  wire logic                 pop,
    output bdenc_pkg::blk_desc_t      head,
    output logic                      not_empty,
    output logic                      full
);
    import bdenc_pkg::*;

    blk_desc_t  ent_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign head      = ent_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("descriptor pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("descriptor popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule
`default_nettype wire

FILE: rtl/bdenc_back.sv
// Back end: holds the two-bank block buffer and emits the flag byte and,
// for literal blocks, the buffered bytes. Depends on bdenc_pkg, bdenc_out_if.
`default_nettype none
module bdenc_back #(
    parameter int BLOCK_BYTES = bdenc_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bdenc_pkg::buf_wr_t   wr,
    input  wire bdenc_pkg::blk_desc_t head,
    input  wire logic                 q_valid,
    output logic                      pop,
    bdenc_out_if.source               code
);
    import bdenc_pkg::*;

    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    typedef enum logic {ST_IDLE, ST_DATA} state_t;

    logic [BYTE_W-1:0] mem [2][BLOCK_BYTES];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              is_flag_reg, is_flag_next;
    logic              run_end_reg, run_end_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
    logic              advance;
    logic [CNT_W-1:0]  emit_inc;
    logic              last_byte;

    assign advance   = !ovalid_reg || code.ready;
    assign emit_inc  = emit_reg + CNT_W'(1);
    assign last_byte = (emit_inc == head.count);

    assign code.valid    = ovalid_reg;
    assign code.out_byte = out_byte_reg;
    assign code.is_flag  = is_flag_reg;
    assign code.run_end  = run_end_reg;

    always_comb
    begin
        state_next    = state_reg;
        emit_next     = emit_reg;
        ovalid_next   = ovalid_reg;
        out_byte_next = out_byte_reg;
        is_flag_next  = is_flag_reg;
        run_end_next  = run_end_reg;
        pop           = 1'b0;
        rd_en         = 1'b0;
        rd_idx        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b0;
                    if (q_valid)
                    begin
                        ovalid_next   = 1'b1;
                        out_byte_next = head.differs ? FLAG_LITERAL : FLAG_MATCH;
                        is_flag_next  = 1'b1;
                        run_end_next  = !head.differs;
                        if (head.differs)
                        begin
                            rd_en      = 1'b1;
                            emit_next  = '0;
                            state_next = ST_DATA;
                        end
                        else
                        begin
                            pop = 1'b1;
                        end
                    end
                end
            end
            ST_DATA:
            begin
                if (advance)
                begin
                    ovalid_next   = 1'b1;
                    out_byte_next = rd_data_reg;
                    is_flag_next  = 1'b0;
                    run_end_next  = last_byte;
                    if (last_byte)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_idx    = emit_inc;
                        emit_next = emit_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.idx[IDX_W-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head.bank][rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            emit_reg     <= '0;
            ovalid_reg   <= 1'b0;
            out_byte_reg <= '0;
            is_flag_reg  <= 1'b0;
            run_end_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            emit_reg     <= emit_next;
            ovalid_reg   <= ovalid_next;
            out_byte_reg <= out_byte_next;
            is_flag_reg  <= is_flag_next;
            run_end_reg  <= run_end_next;
        end
    end

    a_drain_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> q_valid)
        else $error("draining a block with no descriptor at the queue head");

    a_emit_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (emit_reg < head.count))
        else $error("byte index beyond the length of the block");

    a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && is_flag_reg) |->
            (out_byte_reg == FLAG_MATCH || out_byte_reg == FLAG_LITERAL))
        else $error("flag transfer carries an invalid code");

endmodule
`default_nettype wire

FILE: rtl/block_delta_encoder_unit.sv
// Block delta encoder: top level joining front end, descriptor queue and
// back end. Depends on bdenc_pkg, bdenc_in_if, bdenc_out_if and the parts.
//
// Usage: feed carries one snapshot byte per transfer with the reference
// byte, a reference-present flag and a last-byte mark. Bytes are buffered
// in blocks of BLOCK_BYTES; a block closes when full or on the last byte.
// For each block, code carries a flag byte (0 when every byte matched a
// present reference byte, 1 otherwise), followed for a literal block by
// the block's bytes in order; run_end marks the last transfer of a block.
// Output: the flag is offered once the queue has registered the closing
// block's descriptor and the back end has registered the flag byte;
// literal bytes follow at one per cycle while code is ready, and a
// queued block's flag directly follows the last transfer before it.
// Throughput: feed takes one byte per cycle while either buffer bank is
// free. The buffer has two banks, so the front end stalls only when two
// closed blocks wait on the output; the back end's drain rate (one byte
// per cycle while code is ready, flags included) sets the steady rate.
// Reset clears the fill count, the queue and the output register; no
// clearing pass is made over the buffer. When code stalls, the pending
// transfer holds and the queue fills before feed is held off.
`default_nettype none
module block_delta_encoder_unit #(
    parameter int BLOCK_BYTES = bdenc_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bdenc_in_if.sink    feed,
    bdenc_out_if.source code
);
    import bdenc_pkg::*;

    logic      push, pop, q_valid, q_full;
    blk_desc_t push_desc, head;
    buf_wr_t   wr;

    bdenc_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc),
        .wr        (wr)
    );

    bdenc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    bdenc_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .head    (head),
        .q_valid (q_valid),
        .pop     (pop),
        .code    (code)
    );

endmodule
`default_nettype wire
